// ===== sv/nmea_sentence_check_time_extract_assert.svh =====
// ----------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECK_TIME_EXTRACT_ASSERT_SVH
`define NMEA_SENTENCE_CHECK_TIME_EXTRACT_ASSERT_SVH

// same-cycle implication
`define NSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nmea_chk_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA checker package
// Character codes, parser state types, sentence summary and decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nmea_chk_pkg;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam int          TIME_LEN       = 6;
  localparam logic [3:0]  NOT_DIGIT      = 4'hF;
  localparam logic [4:0]  ZONE_RESET     = 5'd8;
  localparam logic [5:0]  HOURS_PER_DAY  = 6'd24;
  localparam logic [6:0]  MAX_HOUR       = 7'd23;

  typedef enum logic [1:0] {
    PH_WAIT_DOLLAR,
    PH_PAYLOAD,
    PH_CKSUM,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SM_IDLE,
    SM_COMMA,
    SM_COMMA_A
  } stat_match_t;

  // snapshot of the sentence state, read when the line feed arrives
  typedef struct packed {
    logic                 framed_ok;
    logic [7:0]           running_xor;
    logic [7:0]           rcv_cksum;
    logic                 status_seen;
    logic                 time_full;
    logic [5:0][3:0]      digits;
  } sent_sum_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [3:0] digit_code(logic [7:0] c);
    logic [3:0] r;
    r = NOT_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = 4'(c - 8'h30);
    end
    return r;
  endfunction

  function automatic logic [6:0] two_digits(logic [3:0] hi, logic [3:0] lo);
    return 7'({3'b000, hi} * 7'd10) + 7'(lo);
  endfunction

endpackage

`default_nettype wire

// ===== sv/nmea_chk_parse.sv =====
// ----------------------------------------------------------------------------
// NMEA checker character parser
// Tracks checksum framing, time digits and the status token per character.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_chk_parse (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   char_acc,
  input  wire logic [7:0]             char_code,
  output nmea_chk_pkg::sent_sum_t     summary
);

  nmea_chk_pkg::phase_t       phase_r, phase_nxt;
  nmea_chk_pkg::stat_match_t  match_r, match_nxt;
  logic [7:0]                 xor_r, xor_nxt;
  logic [7:0]                 cksum_r, cksum_nxt;
  logic [1:0]                 hex_cnt_r, hex_cnt_nxt;
  logic                       bad_r, bad_nxt;
  logic                       comma_r, comma_nxt;
  logic [2:0]                 tcnt_r, tcnt_nxt;
  logic                       status_r, status_nxt;
  logic [5:0][3:0]            digits_r;
  logic                       is_lf;
  logic [4:0]                 hex;
  logic                       dig_wr;

  assign is_lf  = (char_code == nmea_chk_pkg::CH_LF);
  assign hex    = nmea_chk_pkg::hex_decode(char_code);
  assign dig_wr = comma_r && (tcnt_r < 3'(nmea_chk_pkg::TIME_LEN));

  // checksum framing phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_lf) begin
      phase_nxt = nmea_chk_pkg::PH_WAIT_DOLLAR;
    end else begin
      unique case (phase_r)
        nmea_chk_pkg::PH_WAIT_DOLLAR: begin
          if (char_code == nmea_chk_pkg::CH_DOLLAR) phase_nxt = nmea_chk_pkg::PH_PAYLOAD;
        end
        nmea_chk_pkg::PH_PAYLOAD: begin
          if (char_code == nmea_chk_pkg::CH_STAR) phase_nxt = nmea_chk_pkg::PH_CKSUM;
        end
        nmea_chk_pkg::PH_CKSUM: begin
          if (!hex[4] || hex_cnt_r == 2'd1) phase_nxt = nmea_chk_pkg::PH_DONE;
        end
        nmea_chk_pkg::PH_DONE: begin
          phase_nxt = nmea_chk_pkg::PH_DONE;
        end
        default: phase_nxt = nmea_chk_pkg::PH_WAIT_DOLLAR;
      endcase
    end
  end

  // datapath updates driven by the phase and the character
  always_comb begin
    xor_nxt     = xor_r;
    cksum_nxt   = cksum_r;
    hex_cnt_nxt = hex_cnt_r;
    bad_nxt     = bad_r;
    comma_nxt   = comma_r;
    tcnt_nxt    = tcnt_r;
    status_nxt  = status_r;
    match_nxt   = nmea_chk_pkg::SM_IDLE;
    if (is_lf) begin
      xor_nxt     = 8'd0;
      cksum_nxt   = 8'd0;
      hex_cnt_nxt = 2'd0;
      bad_nxt     = 1'b0;
      comma_nxt   = 1'b0;
      tcnt_nxt    = 3'd0;
      status_nxt  = 1'b0;
    end else begin
      if (phase_r == nmea_chk_pkg::PH_PAYLOAD && char_code != nmea_chk_pkg::CH_STAR) begin
        xor_nxt = xor_r ^ char_code;
      end
      if (phase_r == nmea_chk_pkg::PH_CKSUM) begin
        if (hex[4]) begin
          cksum_nxt   = {cksum_r[3:0], hex[3:0]};
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      if (dig_wr) begin
        tcnt_nxt = tcnt_r + 3'd1;
      end else if (!comma_r && char_code == nmea_chk_pkg::CH_COMMA) begin
        comma_nxt = 1'b1;
      end
      if (char_code == nmea_chk_pkg::CH_COMMA) begin
        if (match_r == nmea_chk_pkg::SM_COMMA_A) status_nxt = 1'b1;
        match_nxt = nmea_chk_pkg::SM_COMMA;
      end else if (match_r == nmea_chk_pkg::SM_COMMA && char_code == nmea_chk_pkg::CH_A) begin
        match_nxt = nmea_chk_pkg::SM_COMMA_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= nmea_chk_pkg::PH_WAIT_DOLLAR;
      match_r   <= nmea_chk_pkg::SM_IDLE;
      xor_r     <= 8'd0;
      cksum_r   <= 8'd0;
      hex_cnt_r <= 2'd0;
      bad_r     <= 1'b0;
      comma_r   <= 1'b0;
      tcnt_r    <= 3'd0;
      status_r  <= 1'b0;
    end else if (char_acc) begin
      phase_r   <= phase_nxt;
      match_r   <= match_nxt;
      xor_r     <= xor_nxt;
      cksum_r   <= cksum_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      bad_r     <= bad_nxt;
      comma_r   <= comma_nxt;
      tcnt_r    <= tcnt_nxt;
      status_r  <= status_nxt;
    end
  end

  // digits are only read once all six are written, so no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < nmea_chk_pkg::TIME_LEN; k++) begin
      if (char_acc && !is_lf && dig_wr && tcnt_r == 3'(k)) begin
        digits_r[k] <= nmea_chk_pkg::digit_code(char_code);
      end
    end
  end

  always_comb begin
    summary.framed_ok   = (phase_r == nmea_chk_pkg::PH_DONE) && !bad_r;
    summary.running_xor = xor_r;
    summary.rcv_cksum   = cksum_r;
    summary.status_seen = status_r;
    summary.time_full   = (tcnt_r == 3'(nmea_chk_pkg::TIME_LEN));
    summary.digits      = digits_r;
  end

endmodule

`default_nettype wire

// ===== sv/nmea_sentence_check_time_extract.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker with local time extraction
// One character per beat in; one result beat per line feed out.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_char_code
//   out_    | output    | out_valid/out_stall | check flags, checksum, time
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_zone_offset_hours
//
// One character per cycle unless in_stall holds a line feed; its state update lands at the accepting edge.
// A line feed loads the result register at its accepting edge; the result
// beat is offered on the following cycle.
// Only a line feed is stalled, and only while a result waits under out_stall.
// Synchronous active-low reset; zone offset resets to 8. cfg_ready stays high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nmea_sentence_check_time_extract_assert.svh"

module nmea_sentence_check_time_extract (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_char_code,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_checksum_match,
  output      logic        out_status_active,
  output      logic        out_frame_error,
  output      logic        out_time_valid,
  output      logic [7:0]  out_computed_checksum,
  output      logic [4:0]  out_local_hours,
  output      logic [6:0]  out_minutes,
  output      logic [6:0]  out_seconds,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [4:0]  cfg_zone_offset_hours
);

  nmea_chk_pkg::sent_sum_t  summary;
  logic                     in_acc, is_lf, lf_acc;
  logic [4:0]               zone_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     cmatch_nxt, ferr_nxt, tvalid_nxt;
  logic [4:0]               hours_nxt;
  logic [6:0]               mins_nxt, secs_nxt;
  logic [6:0]               hh, mm, ss;
  logic [5:0]               hsum;
  logic                     digits_ok;
  logic                     cmatch_r, status_r, ferr_r, tvalid_r;
  logic [7:0]               xor_r;
  logic [4:0]               hours_r;
  logic [6:0]               mins_r, secs_r;

  assign is_lf     = (in_char_code == nmea_chk_pkg::CH_LF);
  assign in_stall  = out_valid_r && out_stall && is_lf;
  assign in_acc    = in_valid && !in_stall;
  assign lf_acc    = in_acc && is_lf;
  assign cfg_ready = 1'b1;

  nmea_chk_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_acc  (in_acc),
    .char_code (in_char_code),
    .summary   (summary)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= nmea_chk_pkg::ZONE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      zone_r <= cfg_zone_offset_hours;
    end
  end

  // result from the sentence summary
  always_comb begin
    digits_ok = 1'b1;
    for (int k = 0; k < nmea_chk_pkg::TIME_LEN; k++) begin
      if (summary.digits[k] == nmea_chk_pkg::NOT_DIGIT) digits_ok = 1'b0;
    end
    hh = nmea_chk_pkg::two_digits(summary.digits[0], summary.digits[1]);
    mm = nmea_chk_pkg::two_digits(summary.digits[2], summary.digits[3]);
    ss = nmea_chk_pkg::two_digits(summary.digits[4], summary.digits[5]);
    tvalid_nxt = summary.time_full && digits_ok && (hh <= nmea_chk_pkg::MAX_HOUR);
    hsum = 6'(hh[4:0]) + 6'(zone_r);
    // sum stays below 3 * 24: reduce with two compares
    if (hsum >= 6'(2 * nmea_chk_pkg::HOURS_PER_DAY)) begin
      hsum = hsum - 6'(2 * nmea_chk_pkg::HOURS_PER_DAY);
    end else if (hsum >= nmea_chk_pkg::HOURS_PER_DAY) begin
      hsum = hsum - nmea_chk_pkg::HOURS_PER_DAY;
    end
    hours_nxt  = tvalid_nxt ? hsum[4:0] : 5'd0;
    mins_nxt   = tvalid_nxt ? mm : 7'd0;
    secs_nxt   = tvalid_nxt ? ss : 7'd0;
    ferr_nxt   = !summary.framed_ok;
    cmatch_nxt = summary.framed_ok && (summary.running_xor == summary.rcv_cksum);
  end

  assign out_valid_nxt = lf_acc || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lf_acc) begin
      cmatch_r <= cmatch_nxt;
      status_r <= summary.status_seen;
      ferr_r   <= ferr_nxt;
      tvalid_r <= tvalid_nxt;
      xor_r    <= summary.running_xor;
      hours_r  <= hours_nxt;
      mins_r   <= mins_nxt;
      secs_r   <= secs_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_checksum_match    = cmatch_r;
  assign out_status_active     = status_r;
  assign out_frame_error       = ferr_r;
  assign out_time_valid        = tvalid_r;
  assign out_computed_checksum = xor_r;
  assign out_local_hours       = hours_r;
  assign out_minutes           = mins_r;
  assign out_seconds           = secs_r;

  `NSC_ASSERT_NEXT(a_no_spurious_result, in_acc && !is_lf && !(out_valid_r && out_stall), !out_valid_r, "result beat without a line feed")
  `NSC_ASSERT_NOW(a_match_needs_frame, out_valid_r, !(cmatch_r && ferr_r), "checksum match flagged on a framing error")
  `NSC_ASSERT_NOW(a_invalid_time_zero, out_valid_r && !tvalid_r, hours_r == 5'd0 && mins_r == 7'd0 && secs_r == 7'd0, "time fields nonzero without valid time")
  `NSC_ASSERT_NOW(a_hours_wrapped, out_valid_r && tvalid_r, hours_r < 5'(nmea_chk_pkg::HOURS_PER_DAY), "local hour not wrapped")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the NMEA sentence checker with local time extraction
// Streams directed and random sentence bytes through the character channel,
// tracks the parser in a local predictor and checks every result beat field
// by field. Sender and receiver idle in random bursts, the receiver holds
// off once for a long stretch, and the zone offset is rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 6;
  localparam int LINES_PER   = 9;

  typedef struct packed {
    logic       checksum_match;
    logic       status_active;
    logic       frame_error;
    logic       time_valid;
    logic [7:0] computed_checksum;
    logic [4:0] local_hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
  } fix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_checksum_match;
  logic       out_status_active;
  logic       out_frame_error;
  logic       out_time_valid;
  logic [7:0] out_computed_checksum;
  logic [4:0] out_local_hours;
  logic [6:0] out_minutes;
  logic [6:0] out_seconds;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_zone_offset_hours = 5'd0;

  nmea_sentence_check_time_extract dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_char_code          (in_char_code),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_checksum_match    (out_checksum_match),
    .out_status_active     (out_status_active),
    .out_frame_error       (out_frame_error),
    .out_time_valid        (out_time_valid),
    .out_computed_checksum (out_computed_checksum),
    .out_local_hours       (out_local_hours),
    .out_minutes           (out_minutes),
    .out_seconds           (out_seconds),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_zone_offset_hours (cfg_zone_offset_hours)
  );

  always #5 clk = ~clk;

  // stimulus and expectations
  logic [7:0] char_q [$];
  fix_t       pending_fixes [$];
  fix_t       want;
  int         errors = 0;
  int         idle_pct = 20;
  int         holds_asked = 0;
  int         holds_done = 0;
  int         hold_left = 0;
  int         stall_left = 0;
  int         gap_left = 0;
  int         quiet = 0;
  logic       in_took = 1'b0;

  // sentence tracker state
  logic [4:0]                zone_hours = nmea_chk_pkg::ZONE_RESET;
  nmea_chk_pkg::phase_t      frame_ph = nmea_chk_pkg::PH_WAIT_DOLLAR;
  nmea_chk_pkg::stat_match_t tok = nmea_chk_pkg::SM_IDLE;
  logic [7:0]                xsum = 8'd0;
  logic [7:0]                rsum = 8'd0;
  int                        hexcnt = 0;
  logic                      comma_seen = 1'b0;
  int                        tcount = 0;
  logic [3:0]                tdig [nmea_chk_pkg::TIME_LEN] = '{default: 4'd0};
  logic                      stat_seen = 1'b0;
  logic                      bad_hex = 1'b0;

  task automatic advance_sentence(input logic [7:0] c);
    fix_t f;
    int   hh;
    int   v;
    int   k;
    bit   tv;
    if (c == nmea_chk_pkg::CH_LF) begin
      tv = (tcount == nmea_chk_pkg::TIME_LEN);
      for (k = 0; k < nmea_chk_pkg::TIME_LEN; k++) begin
        if (tdig[k] == nmea_chk_pkg::NOT_DIGIT) tv = 1'b0;
      end
      hh = tdig[0] * 10 + tdig[1];
      if (hh > nmea_chk_pkg::MAX_HOUR) tv = 1'b0;
      f.frame_error       = (frame_ph != nmea_chk_pkg::PH_DONE) || bad_hex;
      f.checksum_match    = !f.frame_error && (xsum == rsum);
      f.status_active     = stat_seen;
      f.time_valid        = tv;
      f.computed_checksum = xsum;
      f.local_hours       = tv ? 5'((hh + zone_hours) % nmea_chk_pkg::HOURS_PER_DAY)
                               : 5'd0;
      f.minutes           = tv ? 7'(tdig[2] * 10 + tdig[3]) : 7'd0;
      f.seconds           = tv ? 7'(tdig[4] * 10 + tdig[5]) : 7'd0;
      pending_fixes.push_back(f);
      frame_ph   = nmea_chk_pkg::PH_WAIT_DOLLAR;
      tok        = nmea_chk_pkg::SM_IDLE;
      xsum       = 8'd0;
      rsum       = 8'd0;
      hexcnt     = 0;
      comma_seen = 1'b0;
      tcount     = 0;
      for (k = 0; k < nmea_chk_pkg::TIME_LEN; k++) tdig[k] = 4'd0;
      stat_seen  = 1'b0;
      bad_hex    = 1'b0;
      return;
    end

    case (frame_ph)
      nmea_chk_pkg::PH_WAIT_DOLLAR: begin
        if (c == nmea_chk_pkg::CH_DOLLAR) frame_ph = nmea_chk_pkg::PH_PAYLOAD;
      end
      nmea_chk_pkg::PH_PAYLOAD: begin
        if (c == nmea_chk_pkg::CH_STAR) frame_ph = nmea_chk_pkg::PH_CKSUM;
        else xsum ^= c;
      end
      nmea_chk_pkg::PH_CKSUM: begin
        v = -1;
        if (c >= "0" && c <= "9") v = c - "0";
        else if (c >= "a" && c <= "f") v = c - "a" + 10;
        else if (c >= "A" && c <= "F") v = c - "A" + 10;
        if (v < 0) begin
          bad_hex  = 1'b1;
          frame_ph = nmea_chk_pkg::PH_DONE;
        end else begin
          rsum = {rsum[3:0], 4'(v)};
          hexcnt++;
          if (hexcnt >= 2) frame_ph = nmea_chk_pkg::PH_DONE;
        end
      end
      default: ;
    endcase

    // six characters after the first comma form hhmmss
    if (comma_seen) begin
      if (tcount < nmea_chk_pkg::TIME_LEN) begin
        tdig[tcount] = (c >= "0" && c <= "9") ? 4'(c - "0") : nmea_chk_pkg::NOT_DIGIT;
        tcount++;
      end
    end else if (c == nmea_chk_pkg::CH_COMMA) begin
      comma_seen = 1'b1;
    end

    if (c == nmea_chk_pkg::CH_COMMA) begin
      if (tok == nmea_chk_pkg::SM_COMMA_A) stat_seen = 1'b1;
      tok = nmea_chk_pkg::SM_COMMA;
    end else if (tok == nmea_chk_pkg::SM_COMMA && c == nmea_chk_pkg::CH_A) begin
      tok = nmea_chk_pkg::SM_COMMA_A;
    end else begin
      tok = nmea_chk_pkg::SM_IDLE;
    end
  endtask

  // driver: hold a stalled beat, otherwise idle or advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        gap_left <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (char_q.size() != 0) begin
        in_valid     <= 1'b1;
        in_char_code <= char_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: one long hold on request, short bursts otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left  <= HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) advance_sentence(in_char_code);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_fixes.size() == 0) begin
        if (errors < 10) begin
          $display("tb: result beat with nothing expected, cks=%02h",
                   out_computed_checksum);
        end
        errors++;
      end else begin
        want = pending_fixes.pop_front();
        if (want.checksum_match !== out_checksum_match ||
            want.status_active !== out_status_active ||
            want.frame_error !== out_frame_error ||
            want.time_valid !== out_time_valid ||
            want.computed_checksum !== out_computed_checksum ||
            want.local_hours !== out_local_hours ||
            want.minutes !== out_minutes ||
            want.seconds !== out_seconds) begin
          if (errors < 10) begin
            $display("tb: mismatch exp match=%0d act=%0d stat=%0d/%0d ferr=%0d/%0d",
                     want.checksum_match, out_checksum_match,
                     want.status_active, out_status_active,
                     want.frame_error, out_frame_error);
            $display("    tv=%0d/%0d cks=%02h/%02h hh=%0d/%0d mm=%0d/%0d ss=%0d/%0d",
                     want.time_valid, out_time_valid,
                     want.computed_checksum, out_computed_checksum,
                     want.local_hours, out_local_hours,
                     want.minutes, out_minutes, want.seconds, out_seconds);
          end
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  task automatic queue_sentence();
    string      body;
    string      digits;
    string      tail;
    string      pool;
    string      nonhex;
    logic [7:0] sum;
    logic [7:0] c;
    int         kind;
    int         i;
    int         n;
    pool   = "0123456789,.NSEWA$";
    nonhex = "gG@`/:z,";
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      // raw noise line
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) char_q.push_back(8'($urandom_range(0, 255)));
      char_q.push_back(nmea_chk_pkg::CH_LF);
      return;
    end

    digits = $sformatf("%02d%02d%02d", $urandom_range(0, 29),
                       $urandom_range(0, 99), $urandom_range(0, 99));
    if ($urandom_range(0, 7) == 0) digits[$urandom_range(0, 5)] = "x";
    if ($urandom_range(0, 9) == 0) digits = digits.substr(0, $urandom_range(0, 4));
    body = $sformatf("GPRMC,%s.00,%s,", digits, ($urandom_range(0, 3) != 0) ? "A" : "V");
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) begin
      body = $sformatf("%s%c", body, pool[$urandom_range(0, pool.len() - 1)]);
    end
    sum = 8'd0;
    for (i = 0; i < body.len(); i++) sum ^= body[i];
    if ($urandom_range(0, 3) == 0) sum ^= 8'($urandom_range(1, 255));
    tail = $sformatf("%02h", sum);
    if ($urandom_range(0, 1) != 0) tail = tail.toupper();

    // leading garbage before the dollar sign
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        c = 8'($urandom_range(0, 255));
        char_q.push_back((c == nmea_chk_pkg::CH_LF) ? nmea_chk_pkg::CH_STAR : c);
      end
    end

    if (kind < 72) begin
      queue_text({"$", body, "*", tail});
      if ($urandom_range(0, 1) != 0) char_q.push_back(8'h0D);
    end else if (kind < 78) begin
      queue_text({body, "*", tail});
    end else if (kind < 84) begin
      queue_text({"$", body});
    end else if (kind < 90) begin
      queue_text({"$", body, "*"});
      if ($urandom_range(0, 1) != 0) char_q.push_back(tail[0]);
      char_q.push_back(nonhex[$urandom_range(0, nonhex.len() - 1)]);
    end else if (kind < 95) begin
      queue_text({"$", body, "*"});
      char_q.push_back(tail[0]);
    end else begin
      queue_text({"$", body, "*", tail, "9z,A,"});
    end
    char_q.push_back(nmea_chk_pkg::CH_LF);
  endtask

  // wait until the block is idle, then let trailing state settle
  task automatic drain();
    while (char_q.size() != 0 || in_valid || pending_fixes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_zone(input logic [4:0] v);
    @(negedge clk);
    cfg_valid             <= 1'b1;
    cfg_zone_offset_hours <= v;
    do @(posedge clk); while (!cfg_ready);
    zone_hours = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  logic [4:0] zone_plan [PHASES];
  int         ph;
  int         j;

  initial begin
    zone_plan = '{5'd0, 5'd31, 5'd23, 5'($urandom_range(0, 31)),
                  5'($urandom_range(24, 31)), 5'd8};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty line, comma before dollar with max hour,
    // extreme bytes and status token with trailing junk, second dollar + bad hex
    char_q.push_back(nmea_chk_pkg::CH_LF);
    queue_text(",235959");
    char_q.push_back(nmea_chk_pkg::CH_LF);
    char_q.push_back(nmea_chk_pkg::CH_DOLLAR);
    char_q.push_back(8'h00);
    char_q.push_back(8'hFF);
    queue_text(",A,*bEx");
    char_q.push_back(nmea_chk_pkg::CH_LF);
    queue_text("$$*2g");
    char_q.push_back(nmea_chk_pkg::CH_LF);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      write_zone(zone_plan[ph]);
      if (ph == 1 || ph == PHASES - 1) idle_pct = 0;
      else idle_pct = $urandom_range(5, 35);
      if (ph == 3) begin
        // back-to-back short lines while the receiver holds off
        for (j = 0; j < 6; j++) begin
          char_q.push_back(nmea_chk_pkg::CH_LF);
          queue_text(",A,");
          char_q.push_back(nmea_chk_pkg::CH_LF);
        end
        holds_asked++;
      end
      for (j = 0; j < LINES_PER; j++) queue_sentence();
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/nmea_chk_pkg.sv
sv/nmea_chk_parse.sv
sv/nmea_sentence_check_time_extract.sv
sim/tb.sv
